### hw/rtl/address_hit_counter_table_macros.svh
// Assertion macros for the address hit counter table.
`ifndef ADDRESS_HIT_COUNTER_TABLE_MACROS_SVH
`define ADDRESS_HIT_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AHCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ahct_pkg.sv
`timescale 1ns / 1ps

package ahct_pkg;

  // Table size; must be a power of two (home slot is a bit field of the address).
  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int ADDR_SHIFT  = 4;

  localparam int ADDR_W      = 32;
  localparam int HITS_W      = 64;
  localparam int SITES_W     = 11;
  localparam int STATUS_W    = 3;
  localparam int SLOT_DW     = ADDR_W + HITS_W;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 80;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ADDR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TARGET = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 8'd3;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_FOUND    = 3'd4,
    ST_ABSENT   = 3'd5
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;       // clear one slot of the sweep
    logic accept;    // take request, read home slot
    logic step;      // read next slot on the probe path
    logic resolve;   // finish the probe, update table
    logic load_out;  // move result to output register
  } ahct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep at final slot
    logic trivial;   // incoming request needs no probe
    logic hit;       // slot read holds the address
    logic empty;     // slot read is empty
    logic last;      // every slot probed
    logic out_free;  // output register can take a result
  } ahct_stat_t;

endpackage

### hw/rtl/ahct_datapath.sv
`timescale 1ns / 1ps

module ahct_datapath
  import ahct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ahct_cmd_t             cmd,
  output ahct_stat_t            stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser
);

  logic [SLOT_DW-1:0] mem [TABLE_SLOTS];
  logic [SLOT_DW-1:0] rd_q_r;

  logic               mem_we, mem_re;
  logic [SLOT_W-1:0]  mem_wa, mem_ra;
  logic [SLOT_DW-1:0] mem_wd;

  // control state
  logic [SLOT_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SITES_W-1:0]    occ_r, occ_nxt;
  logic                  spent_r, spent_nxt;
  logic                  enable_r, enable_nxt;
  logic [ADDR_W-1:0]     alarm_addr_r, alarm_addr_nxt;
  logic [HITS_W-1:0]     alarm_target_r, alarm_target_nxt;
  logic                  alarm_en_r, alarm_en_nxt;

  // payload
  op_t                   op_r, op_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [HITS_W-1:0]     res_total_r, res_total_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  res_fired_r, res_fired_nxt;
  logic [HITS_W-1:0]     out_total_r, out_total_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_fired_r, out_fired_nxt;
  logic [SITES_W-1:0]    out_sites_r, out_sites_nxt;

  logic [ADDR_W-1:0]     rd_addr, in_addr;
  logic [HITS_W-1:0]     rd_hits, inc;
  logic                  sat, fire, alarm_armed;
  logic [SLOT_W-1:0]     home, idx_inc;
  op_t                   in_op;
  status_t               triv_status;

  function automatic logic [SLOT_W-1:0] idx_t_inc(input logic [SLOT_W-1:0] v);
    return v + SLOT_W'(1);
  endfunction

  always_comb begin
    rd_addr     = rd_q_r[ADDR_W-1:0];
    rd_hits     = rd_q_r[SLOT_DW-1:ADDR_W];
    inc         = rd_hits + HITS_W'(1);
    sat         = (rd_hits == HITS_MAX);
    in_addr     = in_tdata[ADDR_W-1:0];
    in_op       = op_t'(in_tuser);
    home        = in_addr[ADDR_SHIFT +: SLOT_W];
    idx_inc     = idx_r + SLOT_W'(1);
    alarm_armed = alarm_en_r && !spent_r && (addr_r == alarm_addr_r);

    stat.clr_last = (clr_idx_r == SLOT_W'(TABLE_SLOTS - 1));
    stat.trivial  = (in_addr == '0) || (in_op == OP_RECORD && !enable_r);
    stat.hit      = (rd_addr == addr_r);
    stat.empty    = (rd_addr == '0);
    stat.last     = (cnt_r == SLOT_W'(TABLE_SLOTS - 1));
    stat.out_free = !out_valid_r || out_tready;

    triv_status = (in_op == OP_QUERY) ? ST_ABSENT : ST_IGNORED;

    clr_idx_nxt      = clr_idx_r;
    out_valid_nxt    = out_valid_r;
    occ_nxt          = occ_r;
    spent_nxt        = spent_r;
    enable_nxt       = enable_r;
    alarm_addr_nxt   = alarm_addr_r;
    alarm_target_nxt = alarm_target_r;
    alarm_en_nxt     = alarm_en_r;
    op_nxt           = op_r;
    addr_nxt         = addr_r;
    idx_nxt          = idx_r;
    cnt_nxt          = cnt_r;
    res_total_nxt    = res_total_r;
    res_status_nxt   = res_status_r;
    res_fired_nxt    = res_fired_r;
    out_total_nxt    = out_total_r;
    out_status_nxt   = out_status_r;
    out_fired_nxt    = out_fired_r;
    out_sites_nxt    = out_sites_r;

    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = idx_inc;
    fire   = 1'b0;

    if (cmd.clr) begin
      mem_we      = 1'b1;
      mem_wa      = clr_idx_r;
      clr_idx_nxt = idx_t_inc(clr_idx_r);
    end

    if (cmd.accept) begin
      op_nxt         = in_op;
      addr_nxt       = in_addr;
      idx_nxt        = home;
      cnt_nxt        = '0;
      mem_re         = 1'b1;
      mem_ra         = home;
      res_total_nxt  = '0;
      res_status_nxt = triv_status;
      res_fired_nxt  = 1'b0;
    end

    if (cmd.step) begin
      idx_nxt = idx_inc;
      cnt_nxt = cnt_r + SLOT_W'(1);
      mem_re  = 1'b1;
      mem_ra  = idx_inc;
    end

    if (cmd.resolve) begin
      res_total_nxt = '0;
      if (op_r == OP_QUERY) begin
        if (stat.hit) begin
          res_total_nxt  = rd_hits;
          res_status_nxt = ST_FOUND;
        end else begin
          res_status_nxt = ST_ABSENT;
        end
      end else if (stat.hit) begin
        res_status_nxt = ST_COUNTED;
        res_total_nxt  = sat ? rd_hits : inc;
        if (!sat) begin
          mem_we = 1'b1;
          mem_wd = {inc, addr_r};
          fire   = alarm_armed && (inc == alarm_target_r);
        end
      end else if (stat.empty) begin
        res_status_nxt = ST_INSERTED;
        res_total_nxt  = HITS_W'(1);
        mem_we         = 1'b1;
        mem_wd         = {HITS_W'(1), addr_r};
        occ_nxt        = occ_r + SITES_W'(1);
        fire           = alarm_armed && (alarm_target_r == HITS_W'(1));
      end else begin
        res_status_nxt = ST_DROPPED;
      end
      res_fired_nxt = fire;
      if (fire) begin
        spent_nxt = 1'b1;
      end
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE: begin
          enable_nxt = cfg_data[0];
        end
        REG_ALARM_ADDR: begin
          alarm_addr_nxt = cfg_data[ADDR_W-1:0];
          spent_nxt      = 1'b0;
        end
        REG_ALARM_TARGET: begin
          alarm_target_nxt = cfg_data[HITS_W-1:0];
          spent_nxt        = 1'b0;
        end
        REG_ALARM_ENABLE: begin
          alarm_en_nxt = cfg_data[0];
          spent_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_total_nxt  = res_total_r;
      out_status_nxt = res_status_r;
      out_fired_nxt  = res_fired_r;
      out_sites_nxt  = occ_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r      <= '0;
      out_valid_r    <= 1'b0;
      occ_r          <= '0;
      spent_r        <= 1'b0;
      enable_r       <= 1'b0;
      alarm_addr_r   <= '0;
      alarm_target_r <= '0;
      alarm_en_r     <= 1'b0;
    end else begin
      clr_idx_r      <= clr_idx_nxt;
      out_valid_r    <= out_valid_nxt;
      occ_r          <= occ_nxt;
      spent_r        <= spent_nxt;
      enable_r       <= enable_nxt;
      alarm_addr_r   <= alarm_addr_nxt;
      alarm_target_r <= alarm_target_nxt;
      alarm_en_r     <= alarm_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    res_total_r  <= res_total_nxt;
    res_status_r <= res_status_nxt;
    res_fired_r  <= res_fired_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_sites_r  <= out_sites_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - HITS_W - 1 - SITES_W)'(0), out_sites_r, out_fired_r,
                       out_total_r};
  assign out_tuser  = out_status_r;

endmodule

### hw/rtl/ahct_ctrl.sv
`timescale 1ns / 1ps
`include "address_hit_counter_table_macros.svh"

module ahct_ctrl
  import ahct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ahct_stat_t stat,
  output ahct_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.trivial ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.hit || stat.empty || stat.last) begin
          cmd.resolve = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `AHCT_ASSERT_IMPL(a_load_free, cmd.load_out, stat.out_free, "result loaded over a pending one")
  `AHCT_ASSERT_IMPL(a_one_cmd, 1'b1,
    $onehot0({cmd.clr, cmd.accept, cmd.step, cmd.resolve, cmd.load_out}),
    "more than one datapath command")
  `AHCT_ASSERT_NEXT(a_accept_next, cmd.accept, state_r == S_PROBE || state_r == S_DONE,
    "accepted request not taken into work")

endmodule

### hw/rtl/address_hit_counter_table.sv
`timescale 1ns / 1ps
// Address hit counter table: per-address hit counts in a linear-probed table.
// Request channel in_*: in_tdata = addr[31:0]; in_tuser = opcode (0 record, 1 query).
// Result channel out_*: out_tdata order from bit 0 - hit_total[63:0], alarm_fired[64],
//   sites_in_use[75:65], zero pad; out_tuser = status[2:0]. One result per request.
// Config channel cfg_*: cfg_index selects enable, alarm_addr, alarm_target,
//   alarm_enable (0..3); writes are always taken; write only while idle.
// Flow: after accept, the probe reads p slots along the probe path (1 at the
//   home slot, up to the table size when full), then the result is loaded;
//   in_tready returns in the cycle after the load, so a new request is taken
//   only once the last one is loaded. Ignored records and queries of address
//   zero skip the probe. The table memory, with one read and one write port,
//   reads one slot per cycle.
// Reset: after rst_n the table is swept to zero, one slot per cycle, over all
//   TABLE_SLOTS (1024) slots; in_tready stays low meanwhile.
// Stall: a result waits in the output register; the next request is accepted
//   and worked on meanwhile, and holds in its final step until the register frees.
module address_hit_counter_table
  import ahct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // addr[31:0]
  input  logic                  in_tuser,   // opcode
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // hit_total[63:0], alarm_fired, sites_in_use[10:0]
  output logic [STATUS_W-1:0]   out_tuser,  // status
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ahct_cmd_t  cmd;
  ahct_stat_t stat;

  // register writes are never back-pressured
  assign cfg_ready = 1'b1;

  ahct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table memory, probe pointer, counters, alarm and output register
  ahct_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ahct_pkg::*;

  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int SETTLE_CYCLES = 8;   // settle time for the block after its last result
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  // one expected result
  typedef struct packed {
    logic [HITS_W-1:0]  hit_total;
    status_t            status;
    logic               alarm_fired;
    logic [SITES_W-1:0] sites;
  } tally_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // addr[31:0]
  logic                  in_tuser   = 1'b0; // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // hit_total[63:0], alarm_fired, sites_in_use[10:0]
  logic [STATUS_W-1:0]   out_tuser;         // status
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  address_hit_counter_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the table, counters and registers
  // ---------------------------------------------------------------------------
  bit [ADDR_W-1:0] seen_addr [TABLE_SLOTS];   // zero = empty slot
  bit [HITS_W-1:0] seen_hits [TABLE_SLOTS];
  int              sites_used = 0;
  bit              alarm_used = 1'b0;
  bit              ctl_enable = 1'b0;
  bit [ADDR_W-1:0] ctl_alarm_addr = '0;
  bit [HITS_W-1:0] ctl_alarm_target = '0;
  bit              ctl_alarm_armed = 1'b0;

  tally_t pending_tallies [$];
  logic [ADDR_W-1:0] addr_pool [$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;   // no idling on either side while set

  // Linear probe from the home slot; stops at the address, the first empty slot, or after a full walk.
  function automatic void find_slot(input logic [ADDR_W-1:0] a, output bit found,
                                    output bit has_empty, output int idx);
    int i;
    found     = 1'b0;
    has_empty = 1'b0;
    idx       = 0;
    i         = int'(a[ADDR_SHIFT +: SLOT_W]);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (seen_addr[i] == a) begin
        found = 1'b1;
        idx   = i;
        return;
      end
      if (seen_addr[i] == '0) begin
        has_empty = 1'b1;
        idx       = i;
        return;
      end
      i = (i + 1) % TABLE_SLOTS;
    end
  endfunction

  function automatic bit alarm_trips(input logic [ADDR_W-1:0] a, input logic [HITS_W-1:0] n);
    if (!ctl_alarm_armed || alarm_used || a != ctl_alarm_addr || n != ctl_alarm_target)
      return 1'b0;
    alarm_used = 1'b1;
    return 1'b1;
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic tally_t predict_tally(input op_t op, input logic [ADDR_W-1:0] a);
    tally_t t;
    bit     found;
    bit     has_empty;
    int     idx;
    t.hit_total   = '0;
    t.alarm_fired = 1'b0;
    found         = 1'b0;
    has_empty     = 1'b0;
    idx           = 0;
    if (a != '0 && (op == OP_QUERY || ctl_enable)) find_slot(a, found, has_empty, idx);
    if (op == OP_QUERY) begin
      t.status = found ? ST_FOUND : ST_ABSENT;
      if (found) t.hit_total = seen_hits[idx];
    end else if (!ctl_enable || a == '0) begin
      t.status = ST_IGNORED;
    end else if (found) begin
      // saturated count stays put and cannot trip the alarm
      if (seen_hits[idx] != HITS_MAX) begin
        seen_hits[idx] += 64'd1;
        t.alarm_fired = alarm_trips(a, seen_hits[idx]);
      end
      t.hit_total = seen_hits[idx];
      t.status    = ST_COUNTED;
    end else if (has_empty) begin
      seen_addr[idx] = a;
      seen_hits[idx] = 64'd1;
      sites_used++;
      t.hit_total   = 64'd1;
      t.status      = ST_INSERTED;
      t.alarm_fired = alarm_trips(a, 64'd1);
    end else begin
      t.status = ST_DROPPED;
    end
    t.sites = sites_used[SITES_W-1:0];
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [ADDR_W-1:0] a);
    if (!steady && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_tallies.push_back(predict_tally(op, a));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ENABLE: ctl_enable = val[0];
      REG_ALARM_ADDR: begin
        ctl_alarm_addr = val[ADDR_W-1:0];
        alarm_used     = 1'b0;
      end
      REG_ALARM_TARGET: begin
        ctl_alarm_target = val;
        alarm_used       = 1'b0;
      end
      REG_ALARM_ENABLE: begin
        ctl_alarm_armed = val[0];
        alarm_used      = 1'b0;
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // 1-bit registers get random upper bits, which must be masked off
  task automatic write_flag(input logic [CFG_IDX_W-1:0] idx, input bit v);
    write_reg(idx, {$urandom, 31'($urandom_range(32'h7FFF_FFFF)), v});
  endtask

  // Sender holds off until every result is back, then lets the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return addr_pool[$urandom_range(addr_pool.size() - 1)];
    if (roll < 95) return $urandom;
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    // disabled after reset: records ignored, queries still answered
    send_request(OP_RECORD, 32'h1234_5670);
    send_request(OP_QUERY,  32'h1234_5670);
    wait_idle();
    write_flag(REG_ENABLE, 1'b1);
    send_request(OP_RECORD, 32'h0000_0000);   // address zero ignored
    send_request(OP_QUERY,  32'h0000_0000);
    send_request(OP_RECORD, 32'hFFFF_FFFF);   // home slot 1023
    send_request(OP_RECORD, 32'hFFFF_FFF0);   // same home, wraps to slot 0
    send_request(OP_RECORD, 32'h0000_0001);   // home 0 taken -> slot 1
    send_request(OP_RECORD, 32'h0000_0010);   // home 1 taken -> slot 2
    send_request(OP_RECORD, 32'hFFFF_FFF0);
    send_request(OP_RECORD, 32'h0000_0010);
    send_request(OP_QUERY,  32'h0000_0001);
    send_request(OP_QUERY,  32'h0000_0010);
    send_request(OP_QUERY,  32'h8000_0000);   // walks the chain to an empty slot
    wait_idle();
    write_reg(REG_ALARM_ADDR, 64'hA5A5_5A5A_FFFF_FFFF);
    write_reg(REG_ALARM_TARGET, 64'd3);
    write_flag(REG_ALARM_ENABLE, 1'b1);
    send_request(OP_RECORD, 32'hFFFF_FFFF);   // count 2
    send_request(OP_RECORD, 32'hFFFF_FFFF);   // count 3 fires
    send_request(OP_RECORD, 32'hFFFF_FFFF);   // spent
    wait_idle();
    write_reg(REG_ALARM_TARGET, 64'd5);       // re-arm
    send_request(OP_RECORD, 32'hFFFF_FFFF);   // count 5 fires
    wait_idle();
    write_reg(REG_ALARM_ADDR, 64'h0000_0000_DEAD_BEE0);
    write_reg(REG_ALARM_TARGET, 64'd1);
    send_request(OP_RECORD, 32'hDEAD_BEE0);   // insert fires at one
    wait_idle();
    write_flag(REG_ENABLE, 1'b0);
    send_request(OP_QUERY,  32'hFFFF_FFFF);
    send_request(OP_RECORD, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] r;
    logic [SLOT_W-1:0] home;
    int                burst;
    // clustered pool: groups share a home slot so probes walk chains
    for (int g = 0; g < 12; g++) begin
      home = (g == 0) ? '1 : SLOT_W'($urandom_range(TABLE_SLOTS - 1));
      for (int k = 0; k < 4; k++) begin
        r = $urandom;
        r[ADDR_SHIFT +: SLOT_W] = home;
        addr_pool.push_back(r);
      end
    end
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_flag(REG_ENABLE, phase != 3);
      case (phase % 3)
        0: write_reg(REG_ALARM_ADDR, {$urandom, addr_pool[$urandom_range(addr_pool.size() - 1)]});
        1: write_reg(REG_ALARM_ADDR, 64'h0000_0000_FFFF_FFFF);
        default: write_reg(REG_ALARM_ADDR, 64'h0);
      endcase
      case (phase)
        0: write_reg(REG_ALARM_TARGET, 64'($urandom_range(4, 1)));
        1: write_reg(REG_ALARM_TARGET, 64'hFFFF_FFFF_FFFF_FFFF);
        2: write_reg(REG_ALARM_TARGET, 64'h0);
        4: write_reg(REG_ALARM_TARGET, 64'($urandom_range(8, 2)));
        default: write_reg(REG_ALARM_TARGET, 64'd1);
      endcase
      write_flag(REG_ALARM_ENABLE, phase != 2);
      write_reg((phase == 5) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO + CFG_IDX_W'(phase),
                {$urandom, $urandom});
      steady = (phase == 2);
      burst  = (phase == 3) ? 30 : 124;
      for (int n = 0; n < burst; n++)
        send_request(($urandom_range(99) < 70) ? OP_RECORD : OP_QUERY, pick_addr());
    end
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_full_table();
    logic [ADDR_W-1:0] watch;
    watch = {16'hA5C3, 12'd500, 4'h9};
    write_flag(REG_ENABLE, 1'b1);
    write_reg(REG_ALARM_ADDR, {32'h0, watch});
    write_reg(REG_ALARM_TARGET, 64'd2);
    write_flag(REG_ALARM_ENABLE, 1'b1);
    // one filler per home slot until every slot is taken
    for (int s = 0; s < 4096 && sites_used < TABLE_SLOTS; s++)
      send_request(OP_RECORD, {16'hA5C3, 12'(s), 4'h9});
    // full table: new addresses dropped after a full walk
    for (int n = 0; n < 3; n++) send_request(OP_RECORD, {16'h5A3C, 16'($urandom)});
    send_request(OP_RECORD, watch);           // count 2 fires
    send_request(OP_QUERY,  {16'hA5C3, 12'd7, 4'h9});
    send_request(OP_QUERY,  {16'h5A3C, 16'($urandom)});
    send_request(OP_QUERY,  32'h0000_0000);
    send_request(OP_RECORD, 32'h0000_0000);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tallies.size() == 0) begin
        $error("result with no request outstanding: tdata %0h tuser %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_tallies.pop_front();
        if (out_tdata[HITS_W-1:0] !== want.hit_total) begin
          $error("hit_total: expected %0h, actual %0h", want.hit_total, out_tdata[HITS_W-1:0]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[HITS_W] !== want.alarm_fired) begin
          $error("alarm_fired: expected %0d, actual %0d", want.alarm_fired, out_tdata[HITS_W]);
          errors++;
        end
        if (out_tdata[HITS_W+1 +: SITES_W] !== want.sites) begin
          $error("sites_in_use: expected %0d, actual %0d", want.sites,
                 out_tdata[HITS_W+1 +: SITES_W]);
          errors++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_full_table();
    if (errors == 0 && pending_tallies.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
